[hdl/triangle_unit_normal_macros.svh]
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// assert under reset qualification
`define TUN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert at every edge, reset included
`define TUN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Default widths shared by the datapath and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int unsigned COORD_WIDTH_DEF      = 16;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

endpackage

`default_nettype wire

[hdl/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, exact squared length, rounded unit normal.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle unless out_stall_i holds the pipeline; one
// restoring divide step per stage and one square root step per stage set the depth.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none

module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0]   a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   a_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]   b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   b_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]   c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   c_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   c_z_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_z_o,
  output logic                                 degenerate_o
);

  localparam int unsigned EW   = COORD_WIDTH + 1;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned SW   = 4 * EW;
  localparam int unsigned SUMW = SW + 2;
  localparam int unsigned RW   = SUMW + 1;
  localparam int unsigned QW   = 2 * NORMAL_FRAC_BITS + 3;
  localparam int unsigned RB   = NORMAL_FRAC_BITS + 2;
  localparam int unsigned SQW  = 2 * RB;
  localparam int unsigned SRW  = RB + 3;
  localparam int unsigned OW   = NORMAL_FRAC_BITS + 2;
  localparam int unsigned DV0  = 6;
  localparam int unsigned SQ0  = DV0 + QW;
  localparam int unsigned OST  = SQ0 + RB;
  localparam int unsigned NST  = OST + 1;

  logic [NST:0]   en;
  logic           v_q [NST];
  logic [2:0]     neg_q [NST];
  logic           deg_q [NST];

  assign en[NST] = !out_stall_i;

  for (genvar k = 0; k < NST; k++) begin : g_valid
    assign en[k] = !v_q[k] || en[k+1];
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en[k]) begin
          v_q[k] <= in_valid_i;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !en[0];

  // edge vectors
  logic signed [COORD_WIDTH-1:0] a_w [3];
  logic signed [COORD_WIDTH-1:0] b_w [3];
  logic signed [COORD_WIDTH-1:0] c_w [3];
  logic signed [EW-1:0]          u_q [3];
  logic signed [EW-1:0]          v_q2 [3];

  assign a_w[0] = a_x_i;
  assign a_w[1] = a_y_i;
  assign a_w[2] = a_z_i;
  assign b_w[0] = b_x_i;
  assign b_w[1] = b_y_i;
  assign b_w[2] = b_z_i;
  assign c_w[0] = c_x_i;
  assign c_w[1] = c_y_i;
  assign c_w[2] = c_z_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i]  <= EW'(b_w[i]) - EW'(a_w[i]);
        v_q2[i] <= EW'(c_w[i]) - EW'(a_w[i]);
      end
    end
  end

  // cross product partial products
  logic signed [PW-1:0] p_q [6];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_q[0] <= u_q[1] * v_q2[2];
      p_q[1] <= u_q[2] * v_q2[1];
      p_q[2] <= u_q[2] * v_q2[0];
      p_q[3] <= u_q[0] * v_q2[2];
      p_q[4] <= u_q[0] * v_q2[1];
      p_q[5] <= u_q[1] * v_q2[0];
    end
  end

  // cross product, sign and magnitude
  logic signed [PW:0] diff_w [3];
  logic [PW-1:0]      mag_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign diff_w[i] = (PW+1)'(p_q[2*i]) - (PW+1)'(p_q[2*i+1]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[2][i] <= diff_w[i][PW];
        mag_q[i]    <= diff_w[i][PW] ? PW'(-diff_w[i]) : PW'(diff_w[i]);
      end
    end
  end

  // squares as three half-width products
  logic [2*EW-1:0] hh_q [3];
  logic [2*EW-1:0] hl_q [3];
  logic [2*EW-1:0] ll_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      neg_q[3] <= neg_q[2];
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= mag_q[i][PW-1:EW] * mag_q[i][PW-1:EW];
        hl_q[i] <= mag_q[i][PW-1:EW] * mag_q[i][EW-1:0];
        ll_q[i] <= mag_q[i][EW-1:0] * mag_q[i][EW-1:0];
      end
    end
  end

  logic [SW-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      neg_q[4] <= neg_q[3];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SW'(hh_q[i]) << (2 * EW)) + (SW'(hl_q[i]) << (EW + 1)) + SW'(ll_q[i]);
      end
    end
  end

  // squared length
  logic [SUMW-1:0] sum_w;
  logic [SUMW-1:0] sum_q;
  logic [SW-1:0]   sq5_q [3];

  assign sum_w = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      neg_q[5] <= neg_q[4];
      deg_q[5] <= (sum_w == '0);
      sum_q    <= sum_w;
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= sq_q[i];
      end
    end
  end

  // restoring divide: floor(sq * 4^(F+1) / sum), one quotient bit per stage
  logic [RW-1:0]   dv_rem_q [QW][3];
  logic [QW-1:0]   dv_quo_q [QW][3];
  logic [SUMW-1:0] dv_s_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0]   rin [3];
    logic [QW-1:0]   qin [3];
    logic [SUMW-1:0] sin;
    logic [RW-1:0]   sh  [3];
    logic [RW-1:0]   dif [3];
    logic            ge  [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (k == 0) begin : g_first
        assign rin[i] = RW'(sq5_q[i]);
        assign qin[i] = '0;
        assign sh[i]  = rin[i];
      end else begin : g_next
        assign rin[i] = dv_rem_q[k-1][i];
        assign qin[i] = dv_quo_q[k-1][i];
        assign sh[i]  = {rin[i][RW-2:0], 1'b0};
      end
      assign ge[i]  = sh[i] >= RW'(sin);
      assign dif[i] = sh[i] - RW'(sin);
    end

    if (k == 0) begin : g_sfirst
      assign sin = sum_q;
    end else begin : g_snext
      assign sin = dv_s_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en[DV0+k]) begin
        neg_q[DV0+k] <= neg_q[DV0+k-1];
        deg_q[DV0+k] <= deg_q[DV0+k-1];
        dv_s_q[k]    <= sin;
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k][i] <= ge[i] ? dif[i] : sh[i];
          dv_quo_q[k][i] <= {qin[i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // restoring square root of the quotient, one root bit per stage
  logic [SQW-1:0] sr_rad_q  [RB][3];
  logic [SRW-1:0] sr_rem_q  [RB][3];
  logic [RB-1:0]  sr_root_q [RB][3];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [SQW-1:0] radin [3];
    logic [SRW-1:0] remin [3];
    logic [RB-1:0]  rtin  [3];
    logic [SRW-1:0] nr    [3];
    logic [SRW-1:0] trial [3];
    logic           ge    [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (j == 0) begin : g_first
        assign radin[i] = SQW'(dv_quo_q[QW-1][i]);
        assign remin[i] = '0;
        assign rtin[i]  = '0;
      end else begin : g_next
        assign radin[i] = sr_rad_q[j-1][i];
        assign remin[i] = sr_rem_q[j-1][i];
        assign rtin[i]  = sr_root_q[j-1][i];
      end
      assign nr[i]    = {remin[i][SRW-3:0], radin[i][SQW-1-2*j -: 2]};
      assign trial[i] = SRW'({rtin[i], 2'b01});
      assign ge[i]    = nr[i] >= trial[i];
    end

    always_ff @(posedge clk_i) begin
      if (en[SQ0+j]) begin
        neg_q[SQ0+j] <= neg_q[SQ0+j-1];
        deg_q[SQ0+j] <= deg_q[SQ0+j-1];
        for (int i = 0; i < 3; i++) begin
          sr_rad_q[j][i]  <= radin[i];
          sr_rem_q[j][i]  <= ge[i] ? (nr[i] - trial[i]) : nr[i];
          sr_root_q[j][i] <= {rtin[i][RB-2:0], ge[i]};
        end
      end
    end
  end

  // round half up on the doubled value, apply sign
  logic [RB:0]           rnd_w [3];
  logic signed [OW-1:0]  nrm_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_rnd
    assign rnd_w[i] = ((RB+1)'(sr_root_q[RB-1][i]) + (RB+1)'(1)) >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en[OST]) begin
      deg_q[OST] <= deg_q[OST-1];
      neg_q[OST] <= neg_q[OST-1];
      for (int i = 0; i < 3; i++) begin
        if (deg_q[OST-1]) begin
          nrm_q[i] <= '0;
        end else if (neg_q[OST-1][i]) begin
          nrm_q[i] <= -OW'(rnd_w[i]);
        end else begin
          nrm_q[i] <= OW'(rnd_w[i]);
        end
      end
    end
  end

  assign out_valid_o  = v_q[OST];
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q[OST];

endmodule

`default_nettype wire

[hdl/tun_checker.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_unit_normal_macros.svh"

module tun_checker #(
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  input wire logic                          degenerate_o
);

  localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE =
    (NORMAL_FRAC_BITS+2)'(1 << NORMAL_FRAC_BITS);

  `TUN_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "valid during reset")

  `TUN_ASSERT(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0, "degenerate result not zero")

  `TUN_ASSERT(a_unit_range, clk_i, rst_ni, out_valid_o |-> normal_x_o <= ONE && normal_x_o >= -ONE && normal_y_o <= ONE && normal_y_o >= -ONE && normal_z_o <= ONE && normal_z_o >= -ONE, "normal component out of range")

  `TUN_ASSERT(a_nonzero, clk_i, rst_ni, out_valid_o && !degenerate_o |-> normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0, "zero normal without degenerate flag")

  `TUN_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(normal_x_o) && $stable(degenerate_o), "stalled result changed")

endmodule

bind triangle_unit_normal tun_checker #(
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .normal_x_o   (normal_x_o),
  .normal_y_o   (normal_y_o),
  .normal_z_o   (normal_z_o),
  .degenerate_o (degenerate_o)
);

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles into the block under random burst and stall patterns and
// checks every normal and degenerate flag against an exact-arithmetic
// predictor: wide integer cross product, rounding by squared comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = tun_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FB = tun_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int unsigned OW = FB + 2;
  localparam int unsigned LATENCY = 7 + (2 * FB + 3) + (FB + 2);
  localparam int unsigned N_RANDOM = 1130;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] comp_t;

  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } face_t;

  typedef struct {
    comp_t nx, ny, nz;
    logic  degen;
  } normal_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  coord_t a_x_i = '0, a_y_i = '0, a_z_i = '0;
  coord_t b_x_i = '0, b_y_i = '0, b_z_i = '0;
  coord_t c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  comp_t  normal_x_o, normal_y_o, normal_z_o;
  logic   degenerate_o;

  face_t   face_q[$];
  normal_t normal_exp_q[$];
  face_t   cur_face;
  int      errors = 0;
  int      results_seen = 0;

  triangle_unit_normal dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Magnitude r: largest r <= 2^FB with (2r-1)^2 * total <= sq << (2*FB+2)
  function automatic comp_t round_comp(longint n, logic [127:0] total);
    logic [127:0] mag, sq, rhs, o;
    longint       r, t;
    r = 0;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    sq = mag * mag;
    rhs = sq << (2 * FB + 2);
    for (int b = FB; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t <= (longint'(1) << FB)) begin
        o = 128'(2 * t - 1);
        if (o * o * total <= rhs) r = t;
      end
    end
    return (n < 0) ? comp_t'(-r) : comp_t'(r);
  endfunction

  function automatic normal_t unit_normal(face_t f);
    longint       ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [127:0] total;
    normal_t      res;
    ux = longint'(f.bx) - longint'(f.ax);
    uy = longint'(f.by) - longint'(f.ay);
    uz = longint'(f.bz) - longint'(f.az);
    vx = longint'(f.cx) - longint'(f.ax);
    vy = longint'(f.cy) - longint'(f.ay);
    vz = longint'(f.cz) - longint'(f.az);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    total = 128'(nx < 0 ? -nx : nx) * 128'(nx < 0 ? -nx : nx)
          + 128'(ny < 0 ? -ny : ny) * 128'(ny < 0 ? -ny : ny)
          + 128'(nz < 0 ? -nz : nz) * 128'(nz < 0 ? -nz : nz);
    if (total == 0) begin
      res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
    end else begin
      res.nx = round_comp(nx, total);
      res.ny = round_comp(ny, total);
      res.nz = round_comp(nz, total);
      res.degen = 1'b0;
    end
    return res;
  endfunction

  function automatic face_t mk_face(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    face_t f;
    f.ax = coord_t'(ax); f.ay = coord_t'(ay); f.az = coord_t'(az);
    f.bx = coord_t'(bx); f.by = coord_t'(by); f.bz = coord_t'(bz);
    f.cx = coord_t'(cx); f.cy = coord_t'(cy); f.cz = coord_t'(cz);
    return f;
  endfunction

  function automatic int rnd_full();
    return int'(coord_t'($urandom()));
  endfunction

  function automatic int rnd_near(int lim);
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  function automatic face_t random_face();
    face_t f;
    int    ax, ay, az, dx, dy, dz, k1, k2;
    case ($urandom_range(0, 5))
      0, 1: f = mk_face(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                        rnd_full(), rnd_full(), rnd_full(), rnd_full());
      2: f = mk_face(rnd_near(4), rnd_near(4), rnd_near(4), rnd_near(4), rnd_near(4),
                     rnd_near(4), rnd_near(4), rnd_near(4), rnd_near(4));
      3: begin
        ax = rnd_full(); ay = rnd_full(); az = rnd_full();
        f = mk_face(ax, ay, az, ax + rnd_near(300), ay + rnd_near(300), az + rnd_near(300),
                    ax + rnd_near(300), ay + rnd_near(300), az + rnd_near(300));
      end
      4: begin
        ax = rnd_near(1000); ay = rnd_near(1000); az = rnd_near(1000);
        dx = rnd_near(30); dy = rnd_near(30); dz = rnd_near(30);
        k1 = rnd_near(40); k2 = rnd_near(40);
        f = mk_face(ax, ay, az, ax + k1 * dx, ay + k1 * dy, az + k1 * dz,
                    ax + k2 * dx, ay + k2 * dy, az + k2 * dz);
      end
      default: begin
        ax = rnd_full(); ay = rnd_full(); az = rnd_full();
        f = mk_face(ax, ay, az, rnd_full(), ay, az, ax, rnd_full(), az);
        if ($urandom_range(0, 1)) f.cz = coord_t'(rnd_full());
      end
    endcase
    return f;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic drive_face(face_t f);
    a_x_i <= f.ax; a_y_i <= f.ay; a_z_i <= f.az;
    b_x_i <= f.bx; b_y_i <= f.by; b_z_i <= f.bz;
    c_x_i <= f.cx; c_y_i <= f.cy; c_z_i <= f.cz;
  endtask

  // Driver: bursts of transfers separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        normal_exp_q.push_back(unit_normal(cur_face));
        void'(face_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (face_q.size() > 0) begin
          cur_face = face_q[0];
          drive_face(cur_face);
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off
  int stall_mode = 0;
  int mode_left = 50;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (--mode_left <= 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 100);
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (normal_exp_q.size() == 0) begin
        $display("%0t: unexpected result transfer", $realtime);
        errors++;
      end else begin
        want = normal_exp_q.pop_front();
        if (normal_x_o !== want.nx) report_mismatch("normal_x", normal_x_o, want.nx);
        if (normal_y_o !== want.ny) report_mismatch("normal_y", normal_y_o, want.ny);
        if (normal_z_o !== want.nz) report_mismatch("normal_z", normal_z_o, want.nz);
        if (degenerate_o !== want.degen)
          report_mismatch("degenerate", degenerate_o, want.degen);
      end
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    face_q.push_back(mk_face(0, 0, 0, 0, 0, 0, 0, 0, 0));
    face_q.push_back(mk_face(-32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768));
    face_q.push_back(mk_face(0, 0, 0, 256, 0, 0, 0, 256, 0));
    face_q.push_back(mk_face(0, 0, 0, 0, 256, 0, 256, 0, 0));
    face_q.push_back(mk_face(0, 0, 0, 0, 256, 0, 0, 0, 256));
    face_q.push_back(mk_face(0, 0, 0, 0, 0, 256, 256, 0, 0));
    face_q.push_back(mk_face(0, 0, 0, 0, 0, 256, 0, 256, 0));
    face_q.push_back(mk_face(0, 0, 0, 1, 0, 0, 0, 1, 0));
    face_q.push_back(mk_face(-32768, -32768, -32768, 32767, -32768, -32768,
                             -32768, 32767, -32768));
    face_q.push_back(mk_face(32767, 32767, 32767, -32768, 32767, 32767,
                             32767, -32768, 32767));
    face_q.push_back(mk_face(-32768, -32768, -32768, 32767, 32767, -32768,
                             -32768, 32767, 32767));
    face_q.push_back(mk_face(32767, -32768, 32767, -32768, 32767, -32768,
                             32767, 32767, -32768));
    face_q.push_back(mk_face(1, 2, 3, 2, 4, 6, 3, 6, 9));
    face_q.push_back(mk_face(-32768, 0, 32767, 32767, 0, -32768, 0, 0, 0));
    face_q.push_back(mk_face(0, 0, 0, 1, 1, 1, 1, 0, 0));
    face_q.push_back(mk_face(0, 0, 0, 3, 4, 0, 0, 0, 5));
    face_q.push_back(mk_face(5, 5, 5, 5, 5, 5, 9, -3, 2));
    face_q.push_back(mk_face(0, 0, 0, 1, 0, 0, 1, 1, 1));
    face_q.push_back(mk_face(-1, -1, -1, 32767, -1, -1, -1, -1, 32767));
    face_q.push_back(mk_face(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0));

    // hold the sender until the pipeline drains
    wait (face_q.size() == 0 && normal_exp_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) face_q.push_back(random_face());

    wait (face_q.size() == 0 && !in_valid_i && normal_exp_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && normal_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", normal_exp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
